// ===== rtl/pdtw_pkg.sv =====
`timescale 1ns / 1ps
package pdtw_pkg;
    localparam int OFF_W   = 16;
    localparam int ROT_W   = 16;
    localparam int GAIN_W  = 20;
    localparam int LIM_W   = 9;
    localparam int THR_W   = 10;
    localparam int CHILD_W = 5;
    localparam int LM_W    = 11;
    localparam int TREE_W  = 12;
    localparam int CODE_W  = 5;
    localparam int FIDX_W  = 17;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;
    localparam int NODE_W  = 4 * OFF_W + THR_W + 2 * CHILD_W;

    localparam logic [1:0] FUNC_NODE = 2'd0;
    localparam logic [1:0] FUNC_PIX  = 2'd1;
    localparam logic [1:0] FUNC_EVAL = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_ROT_XX = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROT_XY = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROT_YX = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROT_YY = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_X = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_Y = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_COLS   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS   = 3'd7;

    // Commands from controller to datapath.
    typedef struct packed {
        logic load;      // capture the input item
        logic node_wr;   // write node store
        logic pix_wr;    // write pixel store
        logic node_rd;   // read current node
        logic mul_a;     // first products of probe 1
        logic mul_b;     // gain products of probe 1 / rotation of probe 2
        logic mul_c;     // gain products of probe 2, probe 1 address ready
        logic mul_d;     // probe 2 address ready, read probe 1
        logic pix_rd2;   // read probe 2
        logic decide;    // compare and pick child
        logic out_load;  // capture result
    } t_cmd;

    typedef struct packed {
        logic in_range;  // evaluate slot is within the store
    } t_stat;
endpackage

// ===== rtl/pdtw_ctrl.sv =====
`timescale 1ns / 1ps
module pdtw_ctrl
    import pdtw_pkg::*;
#(
    parameter int LEVELS = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [1:0] i_func,
    input  t_stat      i_stat,
    input  logic       i_out_free,
    output logic       o_ready,
    output t_cmd       o_cmd
);
    localparam int LVL_W = (LEVELS > 1) ? $clog2(LEVELS) : 1;

    typedef enum logic [3:0] {
        S_IDLE, S_DISP, S_NODE, S_MA, S_MB, S_MC, S_MD, S_P2, S_DEC, S_OUT
    } t_state;

    t_state           r_state;
    logic [1:0]       r_func;
    logic [LVL_W-1:0] r_lvl;

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        o_cmd = '0;
        o_cmd.load     = (r_state == S_IDLE) && i_valid;
        o_cmd.node_wr  = (r_state == S_DISP) && (r_func == FUNC_NODE);
        o_cmd.pix_wr   = (r_state == S_DISP) && (r_func == FUNC_PIX);
        o_cmd.node_rd  = (r_state == S_NODE);
        o_cmd.mul_a    = (r_state == S_MA);
        o_cmd.mul_b    = (r_state == S_MB);
        o_cmd.mul_c    = (r_state == S_MC);
        o_cmd.mul_d    = (r_state == S_MD);
        o_cmd.pix_rd2  = (r_state == S_P2);
        o_cmd.decide   = (r_state == S_DEC);
        o_cmd.out_load = (r_state == S_OUT) && i_out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_func  <= FUNC_NODE;
            r_lvl   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_func  <= i_func;
                        r_state <= S_DISP;
                    end
                end
                S_DISP: begin
                    r_lvl <= '0;
                    if (r_func == FUNC_EVAL && i_stat.in_range) begin
                        r_state <= S_NODE;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_NODE: r_state <= S_MA;
                S_MA:   r_state <= S_MB;
                S_MB:   r_state <= S_MC;
                S_MC:   r_state <= S_MD;
                S_MD:   r_state <= S_P2;
                S_P2:   r_state <= S_DEC;
                S_DEC: begin
                    if (r_lvl == LVL_W'(LEVELS - 1)) begin
                        r_state <= S_OUT;
                    end else begin
                        r_lvl   <= r_lvl + 1'b1;
                        r_state <= S_NODE;
                    end
                end
                S_OUT: begin
                    if (i_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== rtl/pdtw_dp.sv =====
`timescale 1ns / 1ps
module pdtw_dp
    import pdtw_pkg::*;
#(
    parameter int TREE_DEPTH     = 5,
    parameter int TREE_SLOTS     = 64,
    parameter int NODES_PER_TREE = 32,
    parameter int IMAGE_DIM      = 256
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cmd                     i_cmd,
    output t_stat                    o_stat,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]    i_cfg_data,
    input  logic [15:0]              i_addr,
    input  logic signed [OFF_W-1:0]  i_off_x1,
    input  logic signed [OFF_W-1:0]  i_off_y1,
    input  logic signed [OFF_W-1:0]  i_off_x2,
    input  logic signed [OFF_W-1:0]  i_off_y2,
    input  logic signed [THR_W-1:0]  i_value,
    input  logic [CHILD_W-1:0]       i_left_child,
    input  logic [CHILD_W-1:0]       i_right_child,
    input  logic signed [LM_W-1:0]   i_landmark_x,
    input  logic signed [LM_W-1:0]   i_landmark_y,
    input  logic [TREE_W-1:0]        i_tree_number,
    output logic [CODE_W-1:0]        o_leaf_code,
    output logic [FIDX_W-1:0]        o_feature_index
);
    localparam int NODE_WORDS = TREE_SLOTS * NODES_PER_TREE;
    localparam int PIX_WORDS  = IMAGE_DIM * IMAGE_DIM;
    localparam int NADDR_W    = $clog2(NODE_WORDS);
    localparam int NIDX_W     = $clog2(NODES_PER_TREE);
    localparam int DIM_W      = $clog2(IMAGE_DIM);
    localparam int PADDR_W    = $clog2(PIX_WORDS);
    localparam int LEVELS     = TREE_DEPTH - 1;
    localparam int SUM_W      = 33;   // two 16x16 signed products summed
    localparam int PROD_W     = 54;   // sum times unsigned 20-bit gain
    localparam int PIX_OFF_W  = PROD_W - 35;
    localparam int COORD_W    = PIX_OFF_W + 1;

    // Configuration registers.
    logic signed [ROT_W-1:0] r_rxx, r_rxy, r_ryx, r_ryy;
    logic [GAIN_W-1:0]       r_gx, r_gy;
    logic [LIM_W-1:0]        r_cols, r_rows;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rxx  <= 16'sd16384;
            r_rxy  <= '0;
            r_ryx  <= '0;
            r_ryy  <= 16'sd16384;
            r_gx   <= GAIN_W'(256);
            r_gy   <= GAIN_W'(256);
            r_cols <= LIM_W'(256);
            r_rows <= LIM_W'(256);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_ROT_XX: r_rxx  <= i_cfg_data[ROT_W-1:0];
                REG_ROT_XY: r_rxy  <= i_cfg_data[ROT_W-1:0];
                REG_ROT_YX: r_ryx  <= i_cfg_data[ROT_W-1:0];
                REG_ROT_YY: r_ryy  <= i_cfg_data[ROT_W-1:0];
                REG_GAIN_X: r_gx   <= i_cfg_data[GAIN_W-1:0];
                REG_GAIN_Y: r_gy   <= i_cfg_data[GAIN_W-1:0];
                REG_COLS:   r_cols <= i_cfg_data[LIM_W-1:0];
                REG_ROWS:   r_rows <= i_cfg_data[LIM_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective clamp limits minus one.
    function automatic logic [DIM_W-1:0] lim_max(input logic [LIM_W-1:0] r);
        logic [DIM_W-1:0] v;
        if (r == '0) begin
            v = '0;
        end else if (r > LIM_W'(IMAGE_DIM)) begin
            v = DIM_W'(IMAGE_DIM - 1);
        end else begin
            v = DIM_W'(r - 1'b1);
        end
        return v;
    endfunction

    // Captured item.
    logic [15:0]             r_addr;
    logic [NODE_W-1:0]       r_wnode;
    logic [7:0]              r_pix;
    logic signed [LM_W-1:0]  r_lx, r_ly;
    logic [TREE_W-1:0]       r_tree;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_addr  <= i_addr;
            r_wnode <= {i_off_x1, i_off_y1, i_off_x2, i_off_y2, i_value,
                        i_left_child, i_right_child};
            r_pix   <= i_value[7:0];
            r_lx    <= i_landmark_x;
            r_ly    <= i_landmark_y;
            r_tree  <= i_tree_number;
        end
    end

    assign o_stat.in_range = (r_addr < 16'(TREE_SLOTS));

    // Stores.
    logic [NODE_W-1:0] node_mem [NODE_WORDS];
    logic [7:0]        pix_mem  [PIX_WORDS];
    logic [NODE_W-1:0] r_node;
    logic [7:0]        r_p1, r_p2;
    logic [NIDX_W-1:0] r_cur;
    logic [PADDR_W-1:0] r_pa1, r_pa2;

    logic [NADDR_W-1:0] node_raddr;
    assign node_raddr = NADDR_W'(r_addr) * NADDR_W'(NODES_PER_TREE)
                      + NADDR_W'(r_cur);

    always_ff @(posedge i_clk) begin
        if (i_cmd.node_wr && r_addr < 16'(NODE_WORDS)) begin
            node_mem[r_addr[NADDR_W-1:0]] <= r_wnode;
        end
        if (i_cmd.node_rd) begin
            r_node <= node_mem[node_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pix_wr && 32'(r_addr) < PIX_WORDS) begin
            pix_mem[r_addr[PADDR_W-1:0]] <= r_pix;
        end
        if (i_cmd.mul_d) begin
            r_p1 <= pix_mem[r_pa1];
        end
        if (i_cmd.pix_rd2) begin
            r_p2 <= pix_mem[r_pa2];
        end
    end

    // Node fields.
    logic signed [OFF_W-1:0] n_ox1, n_oy1, n_ox2, n_oy2;
    logic signed [THR_W-1:0] n_thr;
    logic [CHILD_W-1:0]      n_lc, n_rc;
    assign {n_ox1, n_oy1, n_ox2, n_oy2, n_thr, n_lc, n_rc} = r_node;

    // Rotation stage: four 16x16 products, summed next.
    logic signed [31:0] r_m0, r_m1, r_m2, r_m3;
    logic signed [SUM_W-1:0] sx, sy;
    logic signed [PROD_W-1:0] r_tx, r_ty;
    logic signed [OFF_W-1:0] rot_ox, rot_oy;

    assign rot_ox = i_cmd.mul_a ? n_ox1 : n_ox2;
    assign rot_oy = i_cmd.mul_a ? n_oy1 : n_oy2;
    assign sx = SUM_W'(r_m0) + SUM_W'(r_m1);
    assign sy = SUM_W'(r_m2) + SUM_W'(r_m3);

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_a || i_cmd.mul_b) begin
            r_m0 <= r_rxx * rot_ox;
            r_m1 <= r_rxy * rot_oy;
            r_m2 <= r_ryx * rot_ox;
            r_m3 <= r_ryy * rot_oy;
        end
        if (i_cmd.mul_b || i_cmd.mul_c) begin
            r_tx <= sx * $signed({1'b0, r_gx});
            r_ty <= sy * $signed({1'b0, r_gy});
        end
    end

    // Truncate toward zero, add landmark, clamp.
    function automatic logic [DIM_W-1:0] place(input logic signed [PROD_W-1:0] t,
                                               input logic signed [LM_W-1:0] lm,
                                               input logic [DIM_W-1:0] mx);
        logic [PROD_W-1:0]          mag;
        logic signed [COORD_W-1:0]  po;
        logic signed [COORD_W:0]    c;
        logic [DIM_W-1:0]           res;
        mag = t[PROD_W-1] ? PROD_W'(-t) : PROD_W'(t);
        mag = mag >> 35;
        po  = t[PROD_W-1] ? -$signed({1'b0, mag[PIX_OFF_W-1:0]})
                          : $signed({1'b0, mag[PIX_OFF_W-1:0]});
        c   = (COORD_W + 1)'(po) + (COORD_W + 1)'(lm);
        if (c < 0) begin
            res = '0;
        end else if (c > $signed({{(COORD_W + 1 - DIM_W){1'b0}}, mx})) begin
            res = mx;
        end else begin
            res = c[DIM_W-1:0];
        end
        return res;
    endfunction

    logic [DIM_W-1:0] cx, cy;
    logic [PADDR_W-1:0] pix_addr;
    assign cx = place(r_tx, r_lx, lim_max(r_cols));
    assign cy = place(r_ty, r_ly, lim_max(r_rows));
    assign pix_addr = PADDR_W'(cy) * PADDR_W'(IMAGE_DIM) + PADDR_W'(cx);

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_c) begin
            r_pa1 <= pix_addr;
        end
        if (i_cmd.mul_d) begin
            r_pa2 <= pix_addr;
        end
    end

    // Decision and leaf code.
    logic signed [9:0]   diff;
    logic [CHILD_W-1:0]  nxt;
    logic [CODE_W-1:0]   r_code;
    logic [CODE_W-1:0]   r_bit;
    logic                go_right;

    assign diff     = $signed({2'b00, r_p1}) - $signed({2'b00, r_p2});
    assign go_right = !(diff < n_thr);
    assign nxt      = go_right ? n_rc : n_lc;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cur  <= '0;
            r_code <= CODE_W'(1);
            r_bit  <= CODE_W'(1) << (LEVELS - 1);
        end else if (i_cmd.decide) begin
            r_cur  <= ((CHILD_W + 1)'(nxt) >= (CHILD_W + 1)'(NODES_PER_TREE))
                    ? NIDX_W'(NODES_PER_TREE - 1) : NIDX_W'(nxt);
            if (go_right) begin
                r_code <= r_code + r_bit;
            end
            r_bit <= r_bit >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_leaf_code     <= r_code;
            o_feature_index <= (FIDX_W'(r_tree) << LEVELS) + FIDX_W'(r_code);
        end
    end
endmodule

// ===== rtl/pixel_difference_tree_walk_core.sv =====
`timescale 1ns / 1ps
// Channel  | Handshake             | Payload
// input    | i_valid / o_ready     | i_func .. i_tree_number
// output   | o_valid / i_ready     | o_leaf_code, o_feature_index
// config   | i_cfg_we (no wait)    | i_cfg_idx, i_cfg_data
//
// A write item is done in the dispatch state. For each tree level, an evaluate
// item reads a node, runs two dependent multiply stages per probe, then reads
// the two pixels from the single-port image memory in turn.
// Reset is synchronous and active low; it restores the register defaults
// and leaves both stores undefined. A result waits in the output register
// while the next item is accepted; only a second result stalls the walk.
module pixel_difference_tree_walk_core
    import pdtw_pkg::*;
#(
    parameter int TREE_DEPTH     = 5,
    parameter int TREE_SLOTS     = 64,
    parameter int NODES_PER_TREE = 32,
    parameter int IMAGE_DIM      = 256
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [1:0]               i_func,
    input  logic [15:0]              i_addr,
    input  logic signed [OFF_W-1:0]  i_off_x1,
    input  logic signed [OFF_W-1:0]  i_off_y1,
    input  logic signed [OFF_W-1:0]  i_off_x2,
    input  logic signed [OFF_W-1:0]  i_off_y2,
    input  logic signed [THR_W-1:0]  i_value,
    input  logic [CHILD_W-1:0]       i_left_child,
    input  logic [CHILD_W-1:0]       i_right_child,
    input  logic signed [LM_W-1:0]   i_landmark_x,
    input  logic signed [LM_W-1:0]   i_landmark_y,
    input  logic [TREE_W-1:0]        i_tree_number,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [CODE_W-1:0]        o_leaf_code,
    output logic [FIDX_W-1:0]        o_feature_index
);
    t_cmd  cmd;
    t_stat stat;
    logic  r_out_valid;
    logic  out_free;

    // The output register is free when empty or being emptied this cycle.
    assign out_free = !r_out_valid || i_ready;
    assign o_valid  = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    pdtw_ctrl #(
        .LEVELS (TREE_DEPTH - 1)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_func     (i_func),
        .i_stat     (stat),
        .i_out_free (out_free),
        .o_ready    (o_ready),
        .o_cmd      (cmd)
    );

    pdtw_dp #(
        .TREE_DEPTH     (TREE_DEPTH),
        .TREE_SLOTS     (TREE_SLOTS),
        .NODES_PER_TREE (NODES_PER_TREE),
        .IMAGE_DIM      (IMAGE_DIM)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_addr          (i_addr),
        .i_off_x1        (i_off_x1),
        .i_off_y1        (i_off_y1),
        .i_off_x2        (i_off_x2),
        .i_off_y2        (i_off_y2),
        .i_value         (i_value),
        .i_left_child    (i_left_child),
        .i_right_child   (i_right_child),
        .i_landmark_x    (i_landmark_x),
        .i_landmark_y    (i_landmark_y),
        .i_tree_number   (i_tree_number),
        .o_leaf_code     (o_leaf_code),
        .o_feature_index (o_feature_index)
    );
endmodule

// ===== rtl/pdtw_checker.sv =====
`timescale 1ns / 1ps
module pdtw_checker
    import pdtw_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_valid,
    input logic              o_ready,
    input logic              o_valid,
    input logic              i_ready,
    input logic [CODE_W-1:0] o_leaf_code,
    input logic [FIDX_W-1:0] o_feature_index
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_leaf_code))
        else $error("result changed while stalled");

    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_leaf_code != '0 && o_feature_index[0] == o_leaf_code[0])
        else $error("leaf code inconsistent with feature index");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("accepted two items in consecutive cycles");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");
endmodule

bind pixel_difference_tree_walk_core pdtw_checker u_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (i_valid),
    .o_ready         (o_ready),
    .o_valid         (o_valid),
    .i_ready         (i_ready),
    .o_leaf_code     (o_leaf_code),
    .o_feature_index (o_feature_index)
);

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
    import pdtw_pkg::*;

    // Geometry of the block as instantiated with its default parameters.
    localparam int DEPTH      = 5;
    localparam int SLOTS      = 64;
    localparam int NODES      = 32;
    localparam int DIM        = 256;
    localparam int NODE_WORDS = SLOTS * NODES;
    // This pause covers one evaluate item with margin.
    localparam int SETTLE     = 40;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_cfg_we;
    logic [CFG_IDX_W-1:0]    i_cfg_idx;
    logic [CFG_DATA_W-1:0]   i_cfg_data;
    logic                    i_valid;
    logic                    o_ready;
    logic [1:0]              i_func;
    logic [15:0]             i_addr;
    logic signed [OFF_W-1:0] i_off_x1;
    logic signed [OFF_W-1:0] i_off_y1;
    logic signed [OFF_W-1:0] i_off_x2;
    logic signed [OFF_W-1:0] i_off_y2;
    logic signed [THR_W-1:0] i_value;
    logic [CHILD_W-1:0]      i_left_child;
    logic [CHILD_W-1:0]      i_right_child;
    logic signed [LM_W-1:0]  i_landmark_x;
    logic signed [LM_W-1:0]  i_landmark_y;
    logic [TREE_W-1:0]       i_tree_number;
    logic                    o_valid;
    logic                    i_ready;
    logic [CODE_W-1:0]       o_leaf_code;
    logic [FIDX_W-1:0]       o_feature_index;

    pixel_difference_tree_walk_core uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_func(i_func), .i_addr(i_addr),
        .i_off_x1(i_off_x1), .i_off_y1(i_off_y1),
        .i_off_x2(i_off_x2), .i_off_y2(i_off_y2),
        .i_value(i_value), .i_left_child(i_left_child), .i_right_child(i_right_child),
        .i_landmark_x(i_landmark_x), .i_landmark_y(i_landmark_y),
        .i_tree_number(i_tree_number),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_leaf_code(o_leaf_code), .o_feature_index(o_feature_index)
    );

    // One input item, laid out as the block's input ports.
    typedef struct {
        logic [1:0]        func;
        logic [15:0]       addr;
        logic signed [15:0] ox1, oy1, ox2, oy2;
        logic signed [9:0] value;
        logic [4:0]        lc, rc;
        logic signed [10:0] lx, ly;
        logic [11:0]       tree;
    } item_t;

    // The result of one tree walk.
    typedef struct {
        logic [CODE_W-1:0] code;
        logic [FIDX_W-1:0] fidx;
    } leaf_t;

    // Our own copy of the block's state: the registers, both stores, and a
    // record of which entries have been written, so that the walk never
    // touches an entry whose contents the block leaves undefined.
    logic [CFG_DATA_W-1:0] cfg_regs [8];
    item_t                 node_mem [NODE_WORDS];
    bit                    node_ok  [NODE_WORDS];
    logic [7:0]            pix_mem  [DIM*DIM];
    bit                    pix_ok   [DIM*DIM];

    leaf_t leaf_q [$];
    int    mismatches;
    int    send_idle;
    int    recv_idle;
    int    sent;

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // The receiver stalls at random, at whatever rate the current phase asks.
    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_idle);
    end

    // Every accepted result is compared with the oldest outstanding walk.
    always @(posedge i_clk) begin
        leaf_t e;
        if (i_rst_n && o_valid && i_ready) begin
            if (leaf_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: code %0d index %0d",
                             o_leaf_code, o_feature_index);
            end else begin
                e = leaf_q.pop_front();
                if (o_leaf_code !== e.code || o_feature_index !== e.fidx) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: expected code %0d index %0d, got %0d %0d",
                                 e.code, e.fidx, o_leaf_code, o_feature_index);
                end
            end
        end
    end

    // Rotation then gain, with the product truncated towards zero.
    function automatic longint project(longint ra, longint rb, longint ox, longint oy,
                                       longint gain);
        longint s;
        longint t;
        longint mag;
        s = ra * ox + rb * oy;
        t = s * gain;
        mag = (t < 0) ? -t : t;
        mag = mag >>> 35;
        return (t < 0) ? -mag : mag;
    endfunction

    // A limit of zero behaves as one and anything above the image as the image.
    function automatic int eff_limit(logic [CFG_DATA_W-1:0] r);
        int v;
        v = int'(r[LIM_W-1:0]);
        if (v == 0)
            return 1;
        return (v > DIM) ? DIM : v;
    endfunction

    function automatic int clamp_coord(longint c, int lim);
        if (c < 0)
            return 0;
        if (c > lim - 1)
            return lim - 1;
        return int'(c);
    endfunction

    function automatic int sat_child(logic [4:0] c);
        return (int'(c) >= NODES) ? NODES - 1 : int'(c);
    endfunction

    function automatic item_t random_item();
        item_t it;
        it.func  = 2'($urandom_range(3));
        it.addr  = 16'($urandom);
        it.ox1   = 16'($urandom);
        it.oy1   = 16'($urandom);
        it.ox2   = 16'($urandom);
        it.oy2   = 16'($urandom);
        it.value = 10'($urandom);
        it.lc    = 5'($urandom);
        it.rc    = 5'($urandom);
        it.lx    = 11'($urandom);
        it.ly    = 11'($urandom);
        it.tree  = 12'($urandom);
        return it;
    endfunction

    // Offers one item and returns at the edge where it is taken. It is always
    // entered just after a rising edge, so valid is never dropped and raised
    // again within one step.
    task automatic send_item(item_t it);
        while ($urandom_range(99) < send_idle) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_func        <= it.func;
        i_addr        <= it.addr;
        i_off_x1      <= it.ox1;
        i_off_y1      <= it.oy1;
        i_off_x2      <= it.ox2;
        i_off_y2      <= it.oy2;
        i_value       <= it.value;
        i_left_child  <= it.lc;
        i_right_child <= it.rc;
        i_landmark_x  <= it.lx;
        i_landmark_y  <= it.ly;
        i_tree_number <= it.tree;
        do
            @(posedge i_clk);
        while (!o_ready);
        sent++;
    endtask

    task automatic write_node(item_t it);
        it.func = FUNC_NODE;
        if (int'(it.addr) < NODE_WORDS) begin
            node_mem[it.addr] = it;
            node_ok[it.addr]  = 1'b1;
        end
        send_item(it);
    endtask

    task automatic write_pixel(int addr, logic [9:0] value);
        item_t it;
        it = random_item();
        it.func  = FUNC_PIX;
        it.addr  = 16'(addr);
        it.value = value;
        pix_mem[addr] = value[7:0];
        pix_ok[addr]  = 1'b1;
        send_item(it);
    endtask

    task automatic fill_pixel(int addr);
        if (!pix_ok[addr])
            write_pixel(addr, 10'($urandom));
    endtask

    // Walks one tree as the block will, writing any node or pixel on the path
    // that has never been written first, then offers the evaluate item and
    // records the leaf it must reach.
    task automatic walk_tree(int slot, logic signed [10:0] lx, logic signed [10:0] ly,
                             logic [11:0] tree);
        item_t nd;
        item_t it;
        leaf_t e;
        int cur;
        int idx;
        int cols;
        int rows;
        int x1, y1, x2, y2;
        int diff;
        logic [4:0] code;
        longint rxx, rxy, ryx, ryy, gx, gy;
        rxx  = $signed(cfg_regs[REG_ROT_XX][15:0]);
        rxy  = $signed(cfg_regs[REG_ROT_XY][15:0]);
        ryx  = $signed(cfg_regs[REG_ROT_YX][15:0]);
        ryy  = $signed(cfg_regs[REG_ROT_YY][15:0]);
        gx   = longint'(cfg_regs[REG_GAIN_X]);
        gy   = longint'(cfg_regs[REG_GAIN_Y]);
        cols = eff_limit(cfg_regs[REG_COLS]);
        rows = eff_limit(cfg_regs[REG_ROWS]);
        cur  = 0;
        code = 5'd1;
        for (int lvl = 0; lvl < DEPTH - 1; lvl++) begin
            idx = slot * NODES + cur;
            if (!node_ok[idx]) begin
                nd = random_item();
                nd.addr = 16'(idx);
                write_node(nd);
            end
            nd = node_mem[idx];
            x1 = clamp_coord(project(rxx, rxy, nd.ox1, nd.oy1, gx) + lx, cols);
            y1 = clamp_coord(project(ryx, ryy, nd.ox1, nd.oy1, gy) + ly, rows);
            x2 = clamp_coord(project(rxx, rxy, nd.ox2, nd.oy2, gx) + lx, cols);
            y2 = clamp_coord(project(ryx, ryy, nd.ox2, nd.oy2, gy) + ly, rows);
            fill_pixel(y1 * DIM + x1);
            fill_pixel(y2 * DIM + x2);
            diff = int'(pix_mem[y1 * DIM + x1]) - int'(pix_mem[y2 * DIM + x2]);
            if (diff < int'(nd.value)) begin
                cur = sat_child(nd.lc);
            end else begin
                cur = sat_child(nd.rc);
                code = code + 5'(1 << (DEPTH - 2 - lvl));
            end
        end
        e.code = code;
        e.fidx = (FIDX_W'(tree) << (DEPTH - 1)) + FIDX_W'(code);
        leaf_q = {leaf_q, e};
        it = random_item();
        it.func = FUNC_EVAL;
        it.addr = 16'(slot);
        it.lx   = lx;
        it.ly   = ly;
        it.tree = tree;
        send_item(it);
    endtask

    // Holds the sender off until every walk has reported, then waits a while
    // longer in case an item that yields nothing is still in flight.
    task automatic drain();
        i_valid <= 1'b0;
        while (leaf_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Rewrites all eight registers back to back, only once the block is idle.
    task automatic write_regs(logic [CFG_DATA_W-1:0] v [8]);
        drain();
        for (int i = 0; i < 8; i++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= CFG_IDX_W'(i);
            i_cfg_data <= v[i];
            cfg_regs[i] = v[i];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    task automatic random_regs();
        logic [CFG_DATA_W-1:0] v [8];
        for (int i = REG_ROT_XX; i <= REG_ROT_YY; i++)
            v[i] = CFG_DATA_W'(16'($urandom));
        // Mostly gains up to 8192, now and then anything.
        v[REG_GAIN_X] = ($urandom_range(3) == 0) ? 20'($urandom) : 20'($urandom_range(8192));
        v[REG_GAIN_Y] = ($urandom_range(3) == 0) ? 20'($urandom) : 20'($urandom_range(8192));
        v[REG_COLS]   = CFG_DATA_W'($urandom_range(511));
        v[REG_ROWS]   = CFG_DATA_W'($urandom_range(511));
        write_regs(v);
    endtask

    // Extreme corners of the register space: the most negative and most
    // positive rotations, zero and full gains, and the narrowest and widest
    // images, including limits of zero and beyond the image.
    task automatic extreme_regs(int which);
        logic [CFG_DATA_W-1:0] v [8];
        case (which)
            0: begin
                v = '{20'h08000, 20'h08000, 20'h08000, 20'h08000, 20'hFFFFF, 20'hFFFFF,
                      20'd0, 20'd0};
            end
            1: begin
                v = '{20'h07FFF, 20'h07FFF, 20'h07FFF, 20'h07FFF, 20'd0, 20'd0,
                      20'd511, 20'd511};
            end
            2: begin
                v = '{20'h07FFF, 20'h08000, 20'h08000, 20'h07FFF, 20'hFFFFF, 20'd1,
                      20'd256, 20'd1};
            end
            default: begin
                v = '{20'd16384, 20'd0, 20'd0, 20'd16384, 20'd256, 20'd256,
                      20'd256, 20'd256};
            end
        endcase
        write_regs(v);
    endtask

    // The directed part: node, threshold and child extremes, the
    // stored pixel losing its upper bits, out-of-range slots and node writes,
    // the unused function code, and landmarks at both ends of their range.
    task automatic test_directed();
        item_t it;
        it = random_item();
        it.addr = 16'd0;
        it.ox1 = 16'sh7FFF; it.oy1 = 16'sh8000; it.ox2 = 16'sh8000; it.oy2 = 16'sh7FFF;
        it.value = -10'sd511; it.lc = 5'd31; it.rc = 5'd0;
        write_node(it);
        it.addr = 16'd31;
        it.ox1 = 16'sh0000; it.oy1 = 16'sh0000; it.ox2 = 16'sh0001; it.oy2 = 16'shFFFF;
        it.value = 10'sd511; it.lc = 5'd0; it.rc = 5'd31;
        write_node(it);
        write_pixel(0, 10'h3FF);
        write_pixel(DIM * DIM - 1, 10'h200);
        walk_tree(0, -11'sd1024, 11'sd1023, 12'd4095);
        walk_tree(0, 11'sd1023, -11'sd1024, 12'd0);
        walk_tree(SLOTS - 1, 11'sd0, 11'sd0, 12'd1);
        // An unused function code, an evaluate past the last slot and a node
        // write past the store must all pass without a result.
        it = random_item();
        it.func = 2'd3;
        send_item(it);
        it.func = FUNC_EVAL;
        it.addr = 16'(SLOTS);
        send_item(it);
        it.addr = 16'hFFFF;
        send_item(it);
        it.addr = 16'hFFFF;
        write_node(it);
        for (int i = 0; i < 4; i++) begin
            extreme_regs(i);
            walk_tree(i, 11'($urandom_range(255)), 11'($urandom_range(255)), 12'($urandom));
            walk_tree(0, -11'sd1024, 11'sd1023, 12'($urandom));
        end
        drain();
    endtask

    // Mostly tree walks with random content over a handful of trees, so that
    // the stores fill and the walks reach every leaf; the rest is writes,
    // overwrites, out-of-range slots and the unused function code. The phase
    // ends once it has sent the given number of items.
    task automatic test_random(int s_idle, int r_idle, int count);
        item_t it;
        int r;
        int slot;
        int stop;
        int n;
        send_idle = s_idle;
        recv_idle = r_idle;
        stop = sent + count;
        n = 0;
        while (sent < stop) begin
            if (n % 100 == 0) begin
                if ($urandom_range(4) == 0)
                    extreme_regs($urandom_range(3));
                else
                    random_regs();
            end
            r = $urandom_range(99);
            slot = ($urandom_range(3) == 0) ? $urandom_range(SLOTS - 1) : $urandom_range(7);
            it = random_item();
            if (r < 60) begin
                if ($urandom_range(4) == 0)
                    walk_tree(slot, it.lx, it.ly, it.tree);
                else
                    walk_tree(slot, 11'($urandom_range(eff_limit(cfg_regs[REG_COLS]))),
                              11'($urandom_range(eff_limit(cfg_regs[REG_ROWS]))), it.tree);
            end else if (r < 75) begin
                if ($urandom_range(7) != 0)
                    it.addr = 16'(slot * NODES + $urandom_range(NODES - 1));
                write_node(it);
            end else if (r < 88) begin
                write_pixel(int'(it.addr), it.value);
            end else if (r < 95) begin
                it.func = FUNC_EVAL;
                it.addr = 16'($urandom_range(16'hFFFF, SLOTS));
                send_item(it);
            end else begin
                it.func = 2'd3;
                send_item(it);
            end
            n++;
        end
        drain();
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= '0;
        i_cfg_data    <= '0;
        i_valid       <= 1'b0;
        i_func        <= '0;
        i_addr        <= '0;
        i_off_x1      <= '0;
        i_off_y1      <= '0;
        i_off_x2      <= '0;
        i_off_y2      <= '0;
        i_value       <= '0;
        i_left_child  <= '0;
        i_right_child <= '0;
        i_landmark_x  <= '0;
        i_landmark_y  <= '0;
        i_tree_number <= '0;
        mismatches = 0;
        send_idle  = 0;
        recv_idle  = 0;
        sent       = 0;
        cfg_regs   = '{20'd16384, 20'd0, 20'd0, 20'd16384, 20'd256, 20'd256,
                       20'd256, 20'd256};
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(16, 53, 450);
        test_random(53, 16, 450);
        test_random(0, 0, 450);

        drain();
        if (mismatches == 0 && leaf_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // A hung handshake ends the run here; the normal run needs far less.
    initial begin
        #20_000_000;
        $display("CHECKS FAILED");
        $finish;
    end
endmodule
